/* hw/rtl/rctc_pkg.sv */
// ----------------------------------------------------------------------------
// rctc_pkg: shared types and constants for the residue convolution block
// Payload structs, fixed-point constants and the exponential coefficient table.
// ----------------------------------------------------------------------------
package rctc_pkg;

	typedef struct packed {
		logic [15:0]        time_stamp;
		logic signed [15:0] arterial_sample;
		logic               start_req;
	} in_t;

	typedef struct packed {
		logic signed [56:0] tissue_sample;
		logic               overflow;
	} out_t;

	localparam int EXP_BITS = 13;
	// flow * 2^24 / 6000 rounded equals flow * 2796 + floor((flow * 76 + 187) / 375).
	localparam logic [11:0] FLOW_MUL_HI = 12'd2796;
	localparam logic [6:0]  FLOW_MUL_LO = 7'd76;
	localparam logic [7:0]  FLOW_RND    = 8'd187;
	// ceil(2^32 / 375); exact for every numerator below 2^23.
	localparam logic [23:0] FLOW_RECIP  = 24'd11453247;
	localparam logic [32:0] E_ONE = 33'h1_0000_0000;

	localparam logic CFG_FLOW    = 1'b0;
	localparam logic CFG_TRANSIT = 1'b1;

	// exp(-2^(b-8)) in Q0.32.
	function automatic logic [31:0] exp_coef(input int b);
		logic [31:0] c;
		case (b)
			0:       c = 32'd4278222805;
			1:       c = 32'd4261543595;
			2:       c = 32'd4228380000;
			3:       c = 32'd4162825045;
			4:       c = 32'd4034748372;
			5:       c = 32'd3790295335;
			6:       c = 32'd3344923892;
			7:       c = 32'd2605029347;
			8:       c = 32'd1580030169;
			9:       c = 32'd581260615;
			10:      c = 32'd78665061;
			11:      c = 32'd1440801;
			12:      c = 32'd483;
			default: c = 32'd0;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/residue_convolution_tissue_curve.sv */
// ----------------------------------------------------------------------------
// residue_convolution_tissue_curve: tissue curve by causal residue convolution
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | in_data  (in_t)
//   out     | output    | out_valid/out_ready | out_data (out_t)
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A frame passes through the flow/6000 reciprocal multiply and the exponential
// cell chain, then its residue is formed and stored, then one multiply-accumulate
// runs per stored frame, limited by the single read port of each history RAM;
// the MAC pipeline then drains and the output is loaded.
// A capacity overflow frame goes straight to the output. Reset clears the frame
// count, overflow flag, settings and control state; the histories need no clearing.
// A new frame is taken while a finished result waits on a stalled output.
// ----------------------------------------------------------------------------
module residue_convolution_tissue_curve
	import rctc_pkg::*;
#(
	parameter int MAX_FRAMES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(MAX_FRAMES);
	localparam int CW = $clog2(MAX_FRAMES + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_EXP  = 3'd2;
	localparam logic [2:0] S_RES  = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_MAC  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]  state_q;
	logic [15:0] flow_q, transit_q;
	logic [CW-1:0] cnt_q, cnt_eff, j_q;
	logic        ovf_q, ovf_eff, full;
	logic [AW-1:0] idx_q;
	logic signed [15:0] art_q;
	logic        before_q, under_q;
	logic [12:0] d_q;
	logic [15:0] d_full;
	logic [27:0] base_hi_q;
	logic [22:0] base_lo_q;
	logic [46:0] base_lo_prod;
	logic [27:0] quot_q;
	logic [5:0]  step_q;
	logic [31:0] res_q;
	logic [63:0] res_prod;
	logic [32:0] e_chain [0:EXP_BITS];
	logic        in_fire, rd_en, rd_v_s1, mul_v_s2;
	logic [31:0] res_rd;
	logic [15:0] art_rd;
	logic signed [48:0] prod_s2;
	logic signed [56:0] acc_q;
	logic signed [57:0] sum;
	logic        res_ovf_q;
	logic        out_valid_q;
	out_t        out_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign cnt_eff  = in_data.start_req ? '0 : cnt_q;
	assign ovf_eff  = in_data.start_req ? 1'b0 : ovf_q;
	assign full     = ovf_eff || (cnt_eff >= CW'(MAX_FRAMES));
	assign d_full   = in_data.time_stamp - transit_q;

	// The low part of flow/6000 is a division by 375, done as a reciprocal multiply.
	assign base_lo_prod = 47'(base_lo_q) * 47'(FLOW_RECIP);

	assign e_chain[0] = E_ONE;
	for (genvar g = 0; g < EXP_BITS; g++) begin : g_exp
		rctc_exp_cell #(.COEF(exp_coef(g))) u_cell (
			.clk    (clk),
			.bit_en (d_q[g]),
			.e_in   (e_chain[g]),
			.e_out  (e_chain[g+1])
		);
	end

	assign res_prod = 64'(quot_q) * 64'(e_chain[EXP_BITS]) + 64'h8000_0000;

	assign rd_en = (state_q == S_MAC) && (j_q <= CW'(idx_q));

	rctc_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_res_ram (
		.clk   (clk),
		.we    (state_q == S_WR),
		.waddr (idx_q),
		.wdata (res_q),
		.re    (rd_en),
		.raddr (idx_q - j_q[AW-1:0]),
		.rdata (res_rd)
	);

	rctc_ram #(.WIDTH(16), .DEPTH(MAX_FRAMES)) u_art_ram (
		.clk   (clk),
		.we    (state_q == S_WR),
		.waddr (idx_q),
		.wdata (art_q),
		.re    (rd_en),
		.raddr (j_q[AW-1:0]),
		.rdata (art_rd)
	);

	assign sum = 58'(acc_q) + 58'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			flow_q      <= '0;
			transit_q   <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			rd_v_s1     <= 1'b0;
			mul_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FLOW) begin
					flow_q <= cfg_data;
				end else begin
					transit_q <= cfg_data;
				end
			end
			rd_v_s1  <= rd_en;
			mul_v_s2 <= rd_v_s1;
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (full) begin
							ovf_q   <= 1'b1;
							cnt_q   <= cnt_eff;
							state_q <= S_DONE;
						end else begin
							ovf_q   <= 1'b0;
							cnt_q   <= cnt_eff + 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: state_q <= S_EXP;
				S_EXP: begin
					if (step_q == 6'(EXP_BITS - 1)) begin
						state_q <= S_RES;
					end
				end
				S_RES: state_q <= S_WR;
				S_WR:  state_q <= S_MAC;
				S_MAC: begin
					if (!rd_en && !rd_v_s1 && !mul_v_s2) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				idx_q     <= cnt_eff[AW-1:0];
				art_q     <= in_data.arterial_sample;
				before_q  <= in_data.time_stamp < transit_q;
				under_q   <= (d_full[15:13] != 3'd0);
				d_q       <= d_full[12:0];
				base_hi_q <= 28'(flow_q) * 28'(FLOW_MUL_HI);
				base_lo_q <= 23'(flow_q) * 23'(FLOW_MUL_LO) + 23'(FLOW_RND);
				quot_q    <= '0;
				step_q    <= '0;
				acc_q     <= '0;
				res_ovf_q <= full;
			end
			S_DIV: begin
				quot_q <= base_hi_q + 28'(base_lo_prod[46:32]);
			end
			S_EXP: begin
				step_q <= step_q + 1'b1;
			end
			S_RES: begin
				if (before_q) begin
					res_q <= 32'(quot_q);
				end else if (under_q) begin
					res_q <= '0;
				end else begin
					res_q <= res_prod[63:32];
				end
				j_q <= '0;
			end
			default: begin
			end
		endcase
		if (rd_en) begin
			j_q <= j_q + 1'b1;
		end
		prod_s2 <= 49'($signed({1'b0, res_rd})) * 49'($signed(art_rd));
		if (mul_v_s2) begin
			if (sum[57] != sum[56]) begin
				acc_q <= sum[57] ? {1'b1, 56'd0} : {1'b0, {56{1'b1}}};
			end else begin
				acc_q <= sum[56:0];
			end
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_q.tissue_sample <= res_ovf_q ? '0 : acc_q;
			out_q.overflow      <= res_ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow |-> out_data.tissue_sample == '0)
		else $error("overflow result carries a nonzero tissue sample");

	a_mac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAC |-> j_q <= CW'(idx_q) + 1'b1)
		else $error("convolution index ran past the current frame");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_FRAMES))
		else $error("frame count exceeds capacity");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !full |=> state_q == S_DIV)
		else $error("stored frame did not start the residue divide");

endmodule

/* hw/rtl/rctc_ram.sv */
// ----------------------------------------------------------------------------
// rctc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rctc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/rctc_exp_cell.sv */
// ----------------------------------------------------------------------------
// rctc_exp_cell: one cell of the exponential chain
// Multiplies the running Q.32 value by its coefficient when its bit is set.
// ----------------------------------------------------------------------------
module rctc_exp_cell
	import rctc_pkg::*;
#(
	parameter logic [31:0] COEF = 32'd0
) (
	input  logic        clk,
	input  logic        bit_en,
	input  logic [32:0] e_in,
	output logic [32:0] e_out
);

	logic [64:0] prod;
	logic [32:0] e_out_s1;

	assign prod = 65'(e_in) * 65'(COEF) + 65'h0_8000_0000;

	always_ff @(posedge clk) begin
		e_out_s1 <= bit_en ? prod[64:32] : e_in;
	end

	assign e_out = e_out_s1;

endmodule

/* tb/sv/residue_convolution_tissue_curve_checker.sv */
// ----------------------------------------------------------------------------
// residue_convolution_tissue_curve_checker: tissue curve predictor and checker
// Watches the configuration port and both channels, keeps its own copy of the
// residue and arterial histories, predicts each tissue sample and compares the
// block's results in order, field by field.
// ----------------------------------------------------------------------------
module residue_convolution_tissue_curve_checker
	import rctc_pkg::*;
#(
	parameter int MAX_FRAMES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_t        out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          failures,
	output int          pending,
	output int          results_seen,
	output int          overflow_seen
);

	localparam logic signed [63:0] SUM_MAX = (64'sd1 <<< 56) - 64'sd1;
	localparam logic signed [63:0] SUM_MIN = -(64'sd1 <<< 56);

	// exp(-2^(b-8)) in Q0.32 for each bit of the time difference.
	localparam logic [31:0] DECAY_STEP [13] = '{
		32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825045,
		32'd4034748372, 32'd3790295335, 32'd3344923892, 32'd2605029347,
		32'd1580030169, 32'd581260615,  32'd78665061,   32'd1440801,
		32'd483
	};

	logic [15:0]        flow_q88;
	logic [15:0]        transit_q88;
	logic [31:0]        residue_hist [MAX_FRAMES];
	logic signed [15:0] arterial_hist [MAX_FRAMES];
	int                 frames_held;
	logic               past_capacity;
	out_t               tissue_due [$];

	function automatic logic [31:0] residue_at(input logic [15:0] t);
		logic [127:0] base;
		logic [127:0] decay;
		logic [127:0] scaled;
		logic [15:0]  d;
		base = ({112'd0, flow_q88} * (128'd1 << 24) + 128'd3000) / 128'd6000;
		if (t < transit_q88)
			return base[31:0];
		d = t - transit_q88;
		if (d >= 16'd8192)
			return 32'd0;
		decay = 128'd1 << 32;
		for (int b = 0; b < 13; b++) begin
			if (d[b])
				decay = (decay * {96'd0, DECAY_STEP[b]} + (128'd1 << 31)) >> 32;
		end
		scaled = (base * decay + (128'd1 << 31)) >> 32;
		return scaled[31:0];
	endfunction

	// Updates the histories for one frame within capacity and returns the expected result.
	function automatic out_t convolve_frame(input in_t frame);
		out_t              r;
		logic signed [63:0] sum;
		int                last;
		r = '0;
		if (frame.start_req) begin
			frames_held = 0;
			past_capacity = 1'b0;
		end
		if (past_capacity || frames_held >= MAX_FRAMES) begin
			past_capacity = 1'b1;
			r.overflow = 1'b1;
			return r;
		end
		last = frames_held;
		residue_hist[last] = residue_at(frame.time_stamp);
		arterial_hist[last] = frame.arterial_sample;
		frames_held = last + 1;
		sum = '0;
		for (int j = 0; j <= last; j++) begin
			sum = sum + $signed({32'd0, residue_hist[last - j]}) *
				64'(arterial_hist[j]);
			if (sum > SUM_MAX)
				sum = SUM_MAX;
			else if (sum < SUM_MIN)
				sum = SUM_MIN;
		end
		r.tissue_sample = sum[56:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			flow_q88 = '0;
			transit_q88 = '0;
			frames_held = 0;
			past_capacity = 1'b0;
			tissue_due.delete();
			failures = 0;
			results_seen = 0;
			overflow_seen = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FLOW)
					flow_q88 = cfg_data;
				else
					transit_q88 = cfg_data;
			end
			if (in_valid && in_ready)
				tissue_due.push_back(convolve_frame(in_data));
			if (out_valid && out_ready) begin
				results_seen++;
				if (out_data.overflow)
					overflow_seen++;
				if (tissue_due.size() == 0) begin
					$error("unexpected result: tissue_sample %0d overflow %0b",
						out_data.tissue_sample, out_data.overflow);
					failures++;
				end else begin
					want = tissue_due.pop_front();
					if (out_data.tissue_sample !== want.tissue_sample) begin
						$error("tissue_sample: expected %0d, actual %0d",
							want.tissue_sample, out_data.tissue_sample);
						failures++;
					end
					if (out_data.overflow !== want.overflow) begin
						$error("overflow: expected %0b, actual %0b",
							want.overflow, out_data.overflow);
						failures++;
					end
				end
			end
		end
		pending = tissue_due.size();
	end

endmodule

/* tb/sv/residue_convolution_tissue_curve_test.sv */
// ----------------------------------------------------------------------------
// residue_convolution_tissue_curve_test: top of the tissue curve testbench
// Drives directed and random frame series under several flow and transit
// settings, with bursty input, a stalling output and one long output hold-off.
// ----------------------------------------------------------------------------
module residue_convolution_tissue_curve_test
	import rctc_pkg::*;
;

	localparam int FRAME_CAP    = 512;
	localparam int FRAME_TARGET = 1170;
	localparam int HOLD_CYCLES  = 3000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	int failures;
	int pending;
	int results_seen;
	int overflow_seen;
	int frames_sent;
	int burst_left;
	bit hold_request;

	residue_convolution_tissue_curve #(.MAX_FRAMES(FRAME_CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	residue_convolution_tissue_curve_checker #(.MAX_FRAMES(FRAME_CAP)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures), .pending(pending),
		.results_seen(results_seen), .overflow_seen(overflow_seen)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#(12 * 3_000_000);
		$display("residue_convolution_tissue_curve_test failed");
		$finish;
	end

	// Receiver: random ready stretches, with one long hold-off on request.
	initial begin
		int stretch;
		out_ready = 1'b0;
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			stretch = $urandom_range(1, 40);
			out_ready <= ($urandom_range(0, 9) < 7);
			repeat (stretch) @(posedge clk);
		end
	end

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Sends one frame; bursts of random length are separated by random gaps.
	task automatic send_frame(input logic [15:0] t, input logic [15:0] art,
		input logic start);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_data <= '{time_stamp: t, arterial_sample: art, start_req: start};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		frames_sent++;
	endtask

	// With mixed set, a series also carries random restarts and random frames.
	task automatic run_series(input int len, input logic [15:0] t_first,
		input bit mixed);
		logic [15:0] t;
		int          next_t;
		logic        start;
		t = t_first;
		for (int k = 0; k < len; k++) begin
			start = (k == 0) || (mixed && ($urandom_range(0, 99) < 2));
			if (mixed && ($urandom_range(0, 99) < 8))
				send_frame(16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
			else
				send_frame(t, 16'($urandom_range(0, 65535)), start);
			next_t = int'(t) + int'($urandom_range(0, 400));
			t = next_t > 65535 ? 16'hFFFF : next_t[15:0];
		end
	endtask

	initial begin
		int          phase;
		logic [15:0] flow_set;
		logic [15:0] transit_set;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_FLOW;
		cfg_data = '0;
		frames_sent = 0;
		burst_left = 0;
		hold_request = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of flow and arterial samples around a one second transit.
		write_reg(CFG_FLOW, 16'hFFFF);
		write_reg(CFG_TRANSIT, 16'h0100);
		send_frame(16'h0000, 16'h7FFF, 1'b1);
		send_frame(16'h0064, 16'h8000, 1'b0);
		send_frame(16'h0100, 16'h7FFF, 1'b0);
		send_frame(16'h0101, 16'hFFFF, 1'b0);
		send_frame(16'h20FF, 16'h0001, 1'b0);
		send_frame(16'h2100, 16'h8000, 1'b0);
		send_frame(16'hFFFF, 16'h0000, 1'b0);
		send_frame(16'h0180, 16'h8000, 1'b1);
		send_frame(16'h1FFF, 16'h7FFF, 1'b0);
		drain();
		write_reg(CFG_FLOW, 16'h0000);
		write_reg(CFG_TRANSIT, 16'h0000);
		send_frame(16'h0000, 16'h7FFF, 1'b1);
		send_frame(16'hFFFF, 16'h8000, 1'b0);
		send_frame(16'h0001, 16'h1234, 1'b0);
		drain();
		write_reg(CFG_FLOW, 16'hFFFF);
		write_reg(CFG_TRANSIT, 16'hFFFF);
		send_frame(16'hFFFF, 16'h7FFF, 1'b1);
		send_frame(16'h0000, 16'h8000, 1'b0);
		send_frame(16'hFFFE, 16'h7FFF, 1'b0);
		send_frame(16'hFFFF, 16'h8000, 1'b0);
		drain();

		phase = 0;
		while (frames_sent < FRAME_TARGET) begin
			case ($urandom_range(0, 4))
				0:       flow_set = 16'hFFFF;
				1:       flow_set = 16'h0000;
				default: flow_set = 16'($urandom_range(0, 65535));
			endcase
			transit_set = $urandom_range(0, 3) == 0 ? 16'h0000 :
				16'($urandom_range(0, 3000));
			write_reg(CFG_FLOW, flow_set);
			write_reg(CFG_TRANSIT, transit_set);
			if (phase == 1) begin
				// A series past capacity, then a fresh series after it.
				run_series(FRAME_CAP + 8, 16'($urandom_range(0, 200)), 1'b0);
				run_series(4, 16'($urandom_range(0, 200)), 1'b1);
			end else begin
				if (phase == 3) begin
					hold_request = 1'b1;
					burst_left = 200;
				end
				run_series(phase == 3 ? 48 : int'($urandom_range(1, 48)),
					16'($urandom_range(0, 2000)), 1'b1);
			end
			drain();
			phase++;
		end

		repeat (100) @(posedge clk);
		$display("Sent %0d frames over %0d settings; %0d results checked, %0d past capacity.",
			frames_sent, phase + 3, results_seen, overflow_seen);
		if (failures == 0 && pending == 0)
			$display("residue_convolution_tissue_curve_test passed");
		else
			$display("residue_convolution_tissue_curve_test failed");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/rctc_pkg.sv
hw/rtl/rctc_ram.sv
hw/rtl/rctc_exp_cell.sv
hw/rtl/residue_convolution_tissue_curve.sv
tb/sv/residue_convolution_tissue_curve_checker.sv
tb/sv/residue_convolution_tissue_curve_test.sv
